// ===== design/btfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btfm_pkg: shared types and constants for the battery temperature monitor
// Holds mode codes, register map, reset values and the config bundle type.
// ----------------------------------------------------------------------------
package btfm_pkg;

    localparam int TEMP_W  = 12;
    localparam int CNT_W   = 8;
    localparam int MODE_W  = 3;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Device mode codes (codes above RUN behave as run)
    localparam logic [MODE_W-1:0] MODE_WAKE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHARGE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TEST   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RUN    = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CHARGE_HIGH = 3'd0;
    localparam logic [2:0] REG_CHARGE_LOW  = 3'd1;
    localparam logic [2:0] REG_RUN_HIGH    = 3'd2;
    localparam logic [2:0] REG_RUN_LOW     = 3'd3;
    localparam logic [2:0] REG_RECOVER_MRG = 3'd4;
    localparam logic [2:0] REG_FAULT_TICKS = 3'd5;
    localparam logic [2:0] REG_RECOV_TICKS = 3'd6;
    localparam logic [2:0] REG_BLANK_TICKS = 3'd7;

    // Reset values
    localparam logic signed [TEMP_W-1:0] RST_CHARGE_HIGH = 12'sd450;
    localparam logic signed [TEMP_W-1:0] RST_CHARGE_LOW  = 12'sd0;
    localparam logic signed [TEMP_W-1:0] RST_RUN_HIGH    = 12'sd600;
    localparam logic signed [TEMP_W-1:0] RST_RUN_LOW     = -12'sd100;
    localparam logic [CNT_W-1:0]         RST_RECOVER_MRG = 8'd20;
    localparam logic [CNT_W-1:0]         RST_FAULT_TICKS = 8'd10;
    localparam logic [CNT_W-1:0]         RST_RECOV_TICKS = 8'd5;
    localparam logic [CNT_W-1:0]         RST_BLANK_TICKS = 8'd15;

    typedef struct packed {
        logic signed [TEMP_W-1:0] charge_high_limit;
        logic signed [TEMP_W-1:0] charge_low_limit;
        logic signed [TEMP_W-1:0] run_high_limit;
        logic signed [TEMP_W-1:0] run_low_limit;
        logic [CNT_W-1:0]         recover_margin;
        logic [CNT_W-1:0]         fault_ticks;
        logic [CNT_W-1:0]         recover_ticks;
        logic [CNT_W-1:0]         blank_ticks;
    } btfm_cfg_t;

    // Saturating increment of an 8-bit count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// ===== design/btfm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btfm_regs: configuration register file
// APB-style write/read port for the eight limit and count registers.
// ----------------------------------------------------------------------------
module btfm_regs
    import btfm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output btfm_cfg_t          cfg
);

    btfm_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] wr_idx;

    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[4:2];
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_high_limit <= RST_CHARGE_HIGH;
            cfg_reg.charge_low_limit  <= RST_CHARGE_LOW;
            cfg_reg.run_high_limit    <= RST_RUN_HIGH;
            cfg_reg.run_low_limit     <= RST_RUN_LOW;
            cfg_reg.recover_margin    <= RST_RECOVER_MRG;
            cfg_reg.fault_ticks       <= RST_FAULT_TICKS;
            cfg_reg.recover_ticks     <= RST_RECOV_TICKS;
            cfg_reg.blank_ticks       <= RST_BLANK_TICKS;
        end else if (wr_en) begin
            case (wr_idx)
                REG_CHARGE_HIGH: cfg_reg.charge_high_limit <= pwdata[TEMP_W-1:0];
                REG_CHARGE_LOW:  cfg_reg.charge_low_limit  <= pwdata[TEMP_W-1:0];
                REG_RUN_HIGH:    cfg_reg.run_high_limit    <= pwdata[TEMP_W-1:0];
                REG_RUN_LOW:     cfg_reg.run_low_limit     <= pwdata[TEMP_W-1:0];
                REG_RECOVER_MRG: cfg_reg.recover_margin    <= pwdata[CNT_W-1:0];
                REG_FAULT_TICKS: cfg_reg.fault_ticks       <= pwdata[CNT_W-1:0];
                REG_RECOV_TICKS: cfg_reg.recover_ticks     <= pwdata[CNT_W-1:0];
                REG_BLANK_TICKS: cfg_reg.blank_ticks       <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux; temperature limits are sign-extended
    always_comb begin
        case (paddr[4:2])
            REG_CHARGE_HIGH: prdata = PDATA_W'(cfg_reg.charge_high_limit);
            REG_CHARGE_LOW:  prdata = PDATA_W'(cfg_reg.charge_low_limit);
            REG_RUN_HIGH:    prdata = PDATA_W'(cfg_reg.run_high_limit);
            REG_RUN_LOW:     prdata = PDATA_W'(cfg_reg.run_low_limit);
            REG_RECOVER_MRG: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.recover_margin};
            REG_FAULT_TICKS: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.fault_ticks};
            REG_RECOV_TICKS: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.recover_ticks};
            REG_BLANK_TICKS: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.blank_ticks};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== design/btfm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btfm_core: monitor datapath
// Input register, one pass of window compare and counter update, result
// register. State advances when the item moves into the result register.
// ----------------------------------------------------------------------------
module btfm_core
    import btfm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  btfm_cfg_t                cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MODE_W-1:0]        in_mode,
    input  logic signed [TEMP_W-1:0] in_temp,
    input  logic                     in_aging,
    input  logic                     in_rf,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_fault,
    output logic                     out_request,
    output logic                     out_cleared
);

    // Input stage
    logic                     in_valid_reg;
    logic [MODE_W-1:0]        in_mode_reg;
    logic signed [TEMP_W-1:0] in_temp_reg;
    logic                     in_aging_reg;
    logic                     in_rf_reg;

    // Monitor state
    logic             fault_reg,  fault_next;
    logic [CNT_W-1:0] oow_reg,    oow_next;
    logic [CNT_W-1:0] recov_reg,  recov_next;
    logic [CNT_W-1:0] blank_reg,  blank_next;
    logic             request_next;

    // Result stage
    logic out_valid_reg;
    logic out_fault_reg, out_request_reg, out_cleared_reg;

    logic res_free, advance;

    logic [CNT_W-1:0]       blank_inc, oow_inc, recov_inc;
    logic                   use_charge;
    logic signed [TEMP_W-1:0] hi, lo;
    logic signed [TEMP_W+1:0] inner_lo, inner_hi, temp_x;
    logic                   outside, inner;

    assign res_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && res_free;
    assign in_ready = !in_valid_reg || res_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_mode_reg  <= in_mode;
            in_temp_reg  <= in_temp;
            in_aging_reg <= in_aging;
            in_rf_reg    <= in_rf;
        end
    end

    // Window selection and compares
    assign use_charge = (in_mode_reg == MODE_CHARGE) ||
                        ((in_mode_reg == MODE_TEST) && in_aging_reg && !in_rf_reg);
    assign hi       = use_charge ? cfg.charge_high_limit : cfg.run_high_limit;
    assign lo       = use_charge ? cfg.charge_low_limit  : cfg.run_low_limit;
    assign temp_x   = (TEMP_W+2)'(in_temp_reg);
    assign inner_lo = (TEMP_W+2)'(lo) + (TEMP_W+2)'($signed({1'b0, cfg.recover_margin}));
    assign inner_hi = (TEMP_W+2)'(hi) - (TEMP_W+2)'($signed({1'b0, cfg.recover_margin}));
    assign outside  = (in_temp_reg > hi) || (in_temp_reg < lo);
    assign inner    = (temp_x > inner_lo) && (temp_x < inner_hi);

    assign blank_inc = sat_inc(blank_reg);
    assign oow_inc   = sat_inc(oow_reg);
    assign recov_inc = sat_inc(recov_reg);

    // Next state of the monitor
    always_comb begin
        fault_next   = fault_reg;
        oow_next     = oow_reg;
        recov_next   = recov_reg;
        blank_next   = blank_reg;
        request_next = 1'b0;
        if (in_mode_reg == MODE_WAKE) begin
            blank_next = '0;
            fault_next = 1'b0;
        end else if (blank_inc < cfg.blank_ticks) begin
            blank_next = blank_inc;
        end else if (in_mode_reg == MODE_OFF) begin
            blank_next = '0;
            fault_next = 1'b0;
        end else begin
            blank_next = cfg.blank_ticks;
            if (outside) begin
                if (oow_inc > cfg.fault_ticks) begin
                    oow_next = cfg.fault_ticks;
                    if (!fault_reg) begin
                        fault_next   = 1'b1;
                        request_next = (in_mode_reg != MODE_CHARGE);
                    end
                end else begin
                    oow_next = oow_inc;
                end
            end else if (inner) begin
                oow_next = '0;
                if (recov_inc > cfg.recover_ticks) begin
                    recov_next = cfg.recover_ticks;
                    fault_next = 1'b0;
                end else begin
                    recov_next = recov_inc;
                end
            end
        end
    end

    // State update as the item completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= 1'b0;
            oow_reg   <= '0;
            recov_reg <= '0;
            blank_reg <= '0;
        end else if (advance) begin
            fault_reg <= fault_next;
            oow_reg   <= oow_next;
            recov_reg <= recov_next;
            blank_reg <= blank_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_fault_reg   <= fault_next;
            out_request_reg <= request_next;
            out_cleared_reg <= fault_reg && !fault_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_fault   = out_fault_reg;
    assign out_request = out_request_reg;
    assign out_cleared = out_cleared_reg;

endmodule

// ===== design/battery_temp_fault_monitor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_temp_fault_monitor_top: battery temperature fault monitor
// Debounced window comparator with hysteresis, one item per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) takes one tick item: temperature in tdata, mode and
//   the two aging flags in tuser. Master stream (m_*) returns one result
//   item per input item: fault flag in tdata, request and clear in tuser.
//   The APB-style port writes and reads the eight limit/count registers
//   at byte addresses 0x00..0x1C; pready is tied high.
// Path: an accepted item is loaded into the input register, then into the
//   result register as soon as that register is free (see Stall).
// Throughput: one item per cycle unless m_tready is low; input and result
//   registers form a two-deep pipeline, state updates as an item enters the
//   result register, so the next item always sees up-to-date counts.
// Reset (aresetn low, synchronous): both stages empty, fault and counts
//   zero, registers back to their defaults.
// Stall: while m_tready is low a held result keeps its value; one more
//   item is taken into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module battery_temp_fault_monitor_top
    import btfm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [11:0] battery_temp, rest zero
    input  logic [4:0]         s_tuser,   // [2:0] device_mode, [3] aging_test,
                                          // [4] aging_rf_active
    // result items
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [0] fault_active, rest zero
    output logic [1:0]         m_tuser,   // [0] enter_error_request,
                                          // [1] fault_cleared_now
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    btfm_cfg_t cfg;
    logic      fault, request, cleared;

    assign pready = 1'b1;

    btfm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    btfm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser[2:0]),
        .in_temp     (s_tdata[TEMP_W-1:0]),
        .in_aging    (s_tuser[3]),
        .in_rf       (s_tuser[4]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_fault   (fault),
        .out_request (request),
        .out_cleared (cleared)
    );

    assign m_tdata = {7'd0, fault};
    assign m_tuser = {cleared, request};

endmodule
